[design/hcqp_pkg.sv]
`timescale 1ns / 1ps
// Package for the HTTP credential query parser.
// Holds the character constants, the field limit, the parse states and the result type.
// Depends on nothing; every module of the block imports it.
package hcqp_pkg;

    localparam int FIELD_MAX = 32;
    localparam logic [5:0] CNT_LIMIT = (FIELD_MAX > 63) ? 6'd63 : 6'(FIELD_MAX);

    localparam logic [7:0] CH_G     = 8'h47;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_QUERY = 8'h3f;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_H     = 8'h48;
    localparam logic [7:0] CH_LN    = 8'h6e;
    localparam logic [7:0] CH_LE    = 8'h65;
    localparam logic [7:0] CH_LT    = 8'h74;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LP    = 8'h70;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LS    = 8'h73;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_FAVICON = 2'd1,
        EV_ROOT    = 2'd2,
        EV_CREDS   = 2'd3
    } hcqp_event_t;

    typedef enum logic [16:0] {
        ST_IDLE  = 17'h00001,
        ST_E     = 17'h00002,
        ST_T     = 17'h00004,
        ST_SP    = 17'h00008,
        ST_SLASH = 17'h00010,
        ST_PATH  = 17'h00020,
        ST_QUERY = 17'h00040,
        ST_NE    = 17'h00080,
        ST_NT    = 17'h00100,
        ST_NEQ   = 17'h00200,
        ST_NAME  = 17'h00400,
        ST_P     = 17'h00800,
        ST_PA    = 17'h01000,
        ST_PS1   = 17'h02000,
        ST_PS2   = 17'h04000,
        ST_PEQ   = 17'h08000,
        ST_PASS  = 17'h10000
    } hcqp_state_t;

    typedef struct packed {
        hcqp_event_t event_res;
        logic        char_valid;
        logic        char_field;
        logic [4:0]  char_index;
        logic [7:0]  char_value;
        logic        name_length_valid;
        logic [5:0]  name_length;
        logic [5:0]  secret_length;
        logic        overflow;
    } hcqp_result_t;

endpackage

[design/hcqp_in_reg.sv]
`timescale 1ns / 1ps
// Input register of the HTTP credential query parser.
// Captures one received byte per transaction and holds it until the parser takes it.
// Depends on hcqp_pkg.
module hcqp_in_reg
    import hcqp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       take,
    output logic       byte_valid,
    output logic [7:0] byte_data
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] data_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            data_reg <= s_tdata;
        end
    end

    assign byte_valid = valid_reg;
    assign byte_data  = data_reg;

endmodule

[design/hcqp_parser.sv]
`timescale 1ns / 1ps
// Parse state machine and field counters of the HTTP credential query parser.
// Works out the result for the held byte and advances its state when the byte is taken.
// Depends on hcqp_pkg.
module hcqp_parser
    import hcqp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         step,
    input  logic [7:0]   byte_in,
    output hcqp_result_t result
);

    hcqp_state_t state_reg;
    hcqp_state_t state_next;
    logic [5:0]  name_count_reg;
    logic [5:0]  name_count_next;
    logic [5:0]  secret_count_reg;
    logic [5:0]  secret_count_next;

    function automatic hcqp_state_t match(input logic [7:0] b, input logic [7:0] want,
                                          input hcqp_state_t nxt);
        return (b == want) ? nxt : ST_IDLE;
    endfunction

    always_comb begin
        state_next        = state_reg;
        name_count_next   = name_count_reg;
        secret_count_next = secret_count_reg;
        result            = '0;
        unique case (state_reg)
            ST_E:     state_next = match(byte_in, CH_E, ST_T);
            ST_T:     state_next = match(byte_in, CH_T, ST_SP);
            ST_SP:    state_next = match(byte_in, CH_SPACE, ST_SLASH);
            ST_SLASH: state_next = match(byte_in, CH_SLASH, ST_PATH);
            ST_NE:    state_next = match(byte_in, CH_LE, ST_NT);
            ST_NT:    state_next = match(byte_in, CH_LT, ST_NEQ);
            ST_NEQ:   state_next = match(byte_in, CH_EQ, ST_NAME);
            ST_P:     state_next = match(byte_in, CH_LP, ST_PA);
            ST_PA:    state_next = match(byte_in, CH_LA, ST_PS1);
            ST_PS1:   state_next = match(byte_in, CH_LS, ST_PS2);
            ST_PS2:   state_next = match(byte_in, CH_LS, ST_PEQ);
            ST_PEQ:   state_next = match(byte_in, CH_EQ, ST_PASS);
            ST_PATH: begin
                if (byte_in == CH_QUERY || byte_in == CH_SPACE) begin
                    state_next = ST_QUERY;
                end else if (byte_in == CH_LF) begin
                    state_next       = ST_IDLE;
                    result.event_res = EV_FAVICON;
                end
            end
            ST_QUERY: begin
                if (byte_in == CH_LN) begin
                    state_next = ST_NE;
                end else begin
                    state_next = ST_IDLE;
                    if (byte_in == CH_H) begin
                        result.event_res = EV_ROOT;
                    end
                end
            end
            ST_NAME: begin
                if (byte_in == CH_AMP) begin
                    result.name_length_valid = 1'b1;
                    result.name_length       = name_count_reg;
                    state_next               = ST_P;
                end else if (name_count_reg >= CNT_LIMIT) begin
                    result.overflow = 1'b1;
                end else begin
                    result.char_valid = 1'b1;
                    result.char_index = name_count_reg[4:0];
                    result.char_value = byte_in;
                    name_count_next   = name_count_reg + 6'd1;
                end
            end
            ST_PASS: begin
                if (byte_in == CH_SPACE) begin
                    result.event_res     = EV_CREDS;
                    result.secret_length = secret_count_reg;
                    state_next           = ST_IDLE;
                end else if (secret_count_reg >= CNT_LIMIT) begin
                    result.overflow = 1'b1;
                end else begin
                    result.char_valid = 1'b1;
                    result.char_field = 1'b1;
                    result.char_index = secret_count_reg[4:0];
                    result.char_value = byte_in;
                    secret_count_next = secret_count_reg + 6'd1;
                end
            end
            default: begin
                name_count_next   = '0;
                secret_count_next = '0;
                state_next        = match(byte_in, CH_G, ST_E);
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            name_count_reg   <= '0;
            secret_count_reg <= '0;
        end else if (step) begin
            state_reg        <= state_next;
            name_count_reg   <= name_count_next;
            secret_count_reg <= secret_count_next;
        end
    end

endmodule

[design/http_credential_query_parser.sv]
`timescale 1ns / 1ps
// HTTP credential query parser: scans a received byte stream for a request line and the
// network name and password fields of its query, one result transaction per byte.
// Path: an accepted byte waits in the input register, and its result is registered before it shows on the master side.
// Throughput: one byte per cycle while the master side does not stall, set by the single-step parse state update.
// Reset: synchronous, active low; clears the parse state, counts and both valid flags.
// Depends on hcqp_pkg, hcqp_in_reg and hcqp_parser.
module http_credential_query_parser
    import hcqp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] byte_in
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [4:0] char_index, [12:5] char_value,
                                   // [18:13] name_length, [24:19] secret_length, rest zero
    output logic [5:0]  m_tuser    // [1:0] event_res, [2] char_valid, [3] char_field,
                                   // [4] name_length_valid, [5] overflow
);

    logic         advance;
    logic         byte_valid;
    logic [7:0]   byte_data;
    logic         step;
    hcqp_result_t result;
    logic         m_valid_reg;
    logic         m_valid_next;
    hcqp_result_t res_reg;

    assign advance = !m_valid_reg || m_tready;
    assign step    = byte_valid && advance;

    hcqp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .take       (advance),
        .byte_valid (byte_valid),
        .byte_data  (byte_data)
    );

    hcqp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .byte_in (byte_data),
        .result  (result)
    );

    assign m_valid_next = advance ? byte_valid : m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, res_reg.secret_length, res_reg.name_length,
                       res_reg.char_value, res_reg.char_index};
    assign m_tuser  = {res_reg.overflow, res_reg.name_length_valid, res_reg.char_field,
                       res_reg.char_valid, res_reg.event_res};

    a_step_lands : assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("A parsed byte did not reach the result register.");

    a_char_or_overflow : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(res_reg.char_valid && res_reg.overflow))
        else $error("A byte was both captured and dropped.");

    a_secret_len_gated : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.event_res != EV_CREDS) |-> res_reg.secret_length == 6'd0)
        else $error("Password length shown without a credentials event.");

    a_name_len_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_reg.name_length_valid) |->
            (res_reg.name_length <= CNT_LIMIT && res_reg.event_res == EV_NONE))
        else $error("Name length result out of range or mixed with an event.");

endmodule

[tb/sv/hcqp_stream_checker.sv]
`timescale 1ns / 1ps
// Stream checker for the HTTP credential query parser. It watches both channels, keeps its own
// byte-by-byte model of the parser and compares every result transaction with that model.
// Depends on hcqp_pkg for the parse states, the character constants and the result layout.
module hcqp_stream_checker
    import hcqp_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [5:0]  m_tuser,
    output int          fail_count,
    output int          pending,
    output int          results_checked,
    output int          creds_seen,
    output int          favicon_seen,
    output int          root_seen,
    output int          dropped_seen
);

    hcqp_state_t  parse_st   = ST_IDLE;
    logic [5:0]   name_cnt   = '0;
    logic [5:0]   secret_cnt = '0;
    hcqp_result_t expected_results[$];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("[%0t] result %0d: %s is %0h, expected %0h",
                 $time, results_checked, what, got, want);
        fail_count++;
    endtask

    function automatic hcqp_result_t parse_byte(input logic [7:0] b);
        hcqp_result_t r;
        logic [7:0]   lit;
        hcqp_state_t  nxt;
        logic         is_lit;
        r      = '0;
        lit    = 8'h00;
        nxt    = ST_IDLE;
        is_lit = 1'b0;
        case (parse_st)
            ST_E:     begin lit = CH_E;     nxt = ST_T;     is_lit = 1'b1; end
            ST_T:     begin lit = CH_T;     nxt = ST_SP;    is_lit = 1'b1; end
            ST_SP:    begin lit = CH_SPACE; nxt = ST_SLASH; is_lit = 1'b1; end
            ST_SLASH: begin lit = CH_SLASH; nxt = ST_PATH;  is_lit = 1'b1; end
            ST_NE:    begin lit = CH_LE;    nxt = ST_NT;    is_lit = 1'b1; end
            ST_NT:    begin lit = CH_LT;    nxt = ST_NEQ;   is_lit = 1'b1; end
            ST_NEQ:   begin lit = CH_EQ;    nxt = ST_NAME;  is_lit = 1'b1; end
            ST_P:     begin lit = CH_LP;    nxt = ST_PA;    is_lit = 1'b1; end
            ST_PA:    begin lit = CH_LA;    nxt = ST_PS1;   is_lit = 1'b1; end
            ST_PS1:   begin lit = CH_LS;    nxt = ST_PS2;   is_lit = 1'b1; end
            ST_PS2:   begin lit = CH_LS;    nxt = ST_PEQ;   is_lit = 1'b1; end
            ST_PEQ:   begin lit = CH_EQ;    nxt = ST_PASS;  is_lit = 1'b1; end
            ST_PATH: begin
                if (b == CH_QUERY || b == CH_SPACE) begin
                    parse_st = ST_QUERY;
                end else if (b == CH_LF) begin
                    parse_st    = ST_IDLE;
                    r.event_res = EV_FAVICON;
                end
            end
            ST_QUERY: begin
                if (b == CH_LN) begin
                    parse_st = ST_NE;
                end else begin
                    if (b == CH_H) begin
                        r.event_res = EV_ROOT;
                    end
                    parse_st = ST_IDLE;
                end
            end
            ST_NAME: begin
                if (b == CH_AMP) begin
                    r.name_length_valid = 1'b1;
                    r.name_length       = name_cnt;
                    parse_st            = ST_P;
                end else if (name_cnt >= CNT_LIMIT) begin
                    r.overflow = 1'b1;
                end else begin
                    r.char_valid = 1'b1;
                    r.char_field = 1'b0;
                    r.char_index = name_cnt[4:0];
                    r.char_value = b;
                    name_cnt     = name_cnt + 6'd1;
                end
            end
            ST_PASS: begin
                if (b == CH_SPACE) begin
                    r.event_res     = EV_CREDS;
                    r.secret_length = secret_cnt;
                    parse_st        = ST_IDLE;
                end else if (secret_cnt >= CNT_LIMIT) begin
                    r.overflow = 1'b1;
                end else begin
                    r.char_valid = 1'b1;
                    r.char_field = 1'b1;
                    r.char_index = secret_cnt[4:0];
                    r.char_value = b;
                    secret_cnt   = secret_cnt + 6'd1;
                end
            end
            default: begin
                name_cnt   = '0;
                secret_cnt = '0;
                parse_st   = (b == CH_G) ? ST_E : ST_IDLE;
            end
        endcase
        if (is_lit) begin
            parse_st = (b == lit) ? nxt : ST_IDLE;
        end
        return r;
    endfunction

    task automatic check_result();
        hcqp_result_t want;
        hcqp_result_t got;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected transaction", {m_tuser, m_tdata[24:0]}, 0);
            return;
        end
        want                   = expected_results.pop_front();
        got.event_res          = hcqp_event_t'(m_tuser[1:0]);
        got.char_valid         = m_tuser[2];
        got.char_field         = m_tuser[3];
        got.name_length_valid  = m_tuser[4];
        got.overflow           = m_tuser[5];
        got.char_index         = m_tdata[4:0];
        got.char_value         = m_tdata[12:5];
        got.name_length        = m_tdata[18:13];
        got.secret_length      = m_tdata[24:19];
        if (got.event_res !== want.event_res)
            report_mismatch("event_res", got.event_res, want.event_res);
        if (got.char_valid !== want.char_valid)
            report_mismatch("char_valid", got.char_valid, want.char_valid);
        if (got.char_field !== want.char_field)
            report_mismatch("char_field", got.char_field, want.char_field);
        if (got.char_index !== want.char_index)
            report_mismatch("char_index", got.char_index, want.char_index);
        if (got.char_value !== want.char_value)
            report_mismatch("char_value", got.char_value, want.char_value);
        if (got.name_length_valid !== want.name_length_valid)
            report_mismatch("name_length_valid", got.name_length_valid, want.name_length_valid);
        if (got.name_length !== want.name_length)
            report_mismatch("name_length", got.name_length, want.name_length);
        if (got.secret_length !== want.secret_length)
            report_mismatch("secret_length", got.secret_length, want.secret_length);
        if (got.overflow !== want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
        if (m_tdata[31:25] !== 7'd0)
            report_mismatch("tdata padding", m_tdata[31:25], 0);
        results_checked++;
        if (want.event_res == EV_CREDS) creds_seen++;
        if (want.event_res == EV_FAVICON) favicon_seen++;
        if (want.event_res == EV_ROOT) root_seen++;
        if (want.overflow) dropped_seen++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            parse_st        = ST_IDLE;
            name_cnt        = '0;
            secret_cnt      = '0;
            expected_results.delete();
            fail_count      = 0;
            results_checked = 0;
            creds_seen      = 0;
            favicon_seen    = 0;
            root_seen       = 0;
            dropped_seen    = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(parse_byte(s_tdata));
            end
            if (m_tvalid && m_tready) begin
                check_result();
            end
        end
        pending = expected_results.size();
    end

endmodule

[tb/sv/http_credential_query_parser_tb.sv]
`timescale 1ns / 1ps
// Top of the regression for the HTTP credential query parser: clock, reset, request stimulus
// with random idling on both channels, and the final verdict.
// Depends on hcqp_pkg, the parser itself and hcqp_stream_checker.
module http_credential_query_parser_tb;
    import hcqp_pkg::*;

    localparam int CLK_HALF   = 5;
    localparam int LONG_HOLD  = 200;
    localparam int RAND_BYTES = 400;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [5:0]  m_tuser;

    int fail_count;
    int pending;
    int results_checked;
    int creds_seen;
    int favicon_seen;
    int root_seen;
    int dropped_seen;

    bit         tx_steady = 1'b0;
    bit         long_hold = 1'b0;
    logic [7:0] req_bytes[$];

    always #CLK_HALF aclk = ~aclk;

    http_credential_query_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hcqp_stream_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .fail_count      (fail_count),
        .pending         (pending),
        .results_checked (results_checked),
        .creds_seen      (creds_seen),
        .favicon_seen    (favicon_seen),
        .root_seen       (root_seen),
        .dropped_seen    (dropped_seen)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int field_len(input bit force_long);
        if (force_long) return $urandom_range(int'(CNT_LIMIT) + 1, int'(CNT_LIMIT) + 8);
        if ($urandom_range(0, 7) == 0) return $urandom_range(int'(CNT_LIMIT) - 4, 40);
        return $urandom_range(0, 10);
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            req_bytes.push_back(s[i]);
        end
    endfunction

    function automatic void add_path();
        int         n;
        logic [7:0] b;
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            do begin
                b = 8'($urandom_range(0, 255));
            end while (b == CH_QUERY || b == CH_SPACE || b == CH_LF);
            req_bytes.push_back(b);
        end
    endfunction

    function automatic void add_field(input int len, input logic [7:0] stop);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            do begin
                b = 8'($urandom_range(0, 255));
            end while (b == stop);
            req_bytes.push_back(b);
        end
    endfunction

    function automatic void cut_and_corrupt(input int base);
        int cut;
        cut = $urandom_range(base + 1, req_bytes.size() - 1);
        while (req_bytes.size() > cut) begin
            void'(req_bytes.pop_back());
        end
        req_bytes.push_back($urandom_range(0, 1) ? CH_G : 8'($urandom_range(0, 255)));
    endfunction

    // A broken request is cut inside the request line, its name key or the password key, and the
    // first missing byte is replaced by a random one, often a fresh 'G'.
    function automatic void add_creds(input int nlen, input int plen, input int broken);
        int base;
        base = req_bytes.size();
        add_text("GET /");
        add_path();
        req_bytes.push_back($urandom_range(0, 1) ? CH_QUERY : CH_SPACE);
        add_text("net=");
        if (broken == 1) begin
            cut_and_corrupt(base);
            return;
        end
        add_field(nlen, CH_AMP);
        req_bytes.push_back(CH_AMP);
        base = req_bytes.size();
        add_text("pass=");
        if (broken == 2) begin
            cut_and_corrupt(base - 1);
            return;
        end
        add_field(plen, CH_SPACE);
        req_bytes.push_back(CH_SPACE);
    endfunction

    function automatic void add_favicon();
        add_text("GET /");
        add_path();
        req_bytes.push_back(CH_LF);
        if ($urandom_range(0, 1)) add_text("avicon.ico");
    endfunction

    function automatic void add_root();
        add_text("GET /");
        add_path();
        req_bytes.push_back($urandom_range(0, 1) ? CH_QUERY : CH_SPACE);
        req_bytes.push_back(CH_H);
        if ($urandom_range(0, 1)) add_text("TTP/1.1");
    endfunction

    function automatic void add_noise();
        add_field($urandom_range(1, 6), CH_G);
        if ($urandom_range(0, 3) == 0) req_bytes.push_back(CH_G);
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_steady ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_request();
        foreach (req_bytes[i]) begin
            send_byte(req_bytes[i]);
        end
        req_bytes.delete();
    endtask

    initial begin
        int  stall;
        int  run;
        bit  rx_steady;
        rx_steady = 1'b0;
        forever begin
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else begin
                stall = rx_steady ? 0 : pick_gap();
                if (stall > 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(negedge aclk);
                end
                m_tready <= 1'b1;
                run = $urandom_range(1, 12);
                repeat (run) @(negedge aclk);
                if ($urandom_range(0, 15) == 0) rx_steady = ~rx_steady;
            end
        end
    end

    initial begin
        #(4_000_000);
        $display("http_credential_query_parser regression: fail");
        $finish;
    end

    initial begin
        int req;
        int pick;
        int random_bytes;
        req          = 0;
        random_bytes = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        add_text("GET /");
        req_bytes.push_back(CH_LF);
        add_text("GET /");
        req_bytes.push_back(CH_SPACE);
        req_bytes.push_back(CH_H);
        add_text("GET /?net=");
        req_bytes.push_back(8'h00);
        req_bytes.push_back(8'hff);
        req_bytes.push_back(CH_AMP);
        add_text("pass=");
        req_bytes.push_back(8'hff);
        req_bytes.push_back(CH_SPACE);
        send_request();

        while (random_bytes < RAND_BYTES) begin
            if (req == 4) long_hold = 1'b1;
            if (req == 9) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                wait (pending == 0);
            end
            if ($urandom_range(0, 4) == 0) tx_steady = ~tx_steady;
            pick = (req < 3) ? 0 : $urandom_range(0, 99);
            if (pick < 50) add_creds(field_len(req == 1), field_len(req == 2), 0);
            else if (pick < 60) add_favicon();
            else if (pick < 70) add_root();
            else if (pick < 85) add_creds(field_len(1'b0), field_len(1'b0), $urandom_range(1, 2));
            else add_noise();
            random_bytes += req_bytes.size();
            send_request();
            req++;
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge aclk);
        $display("Checked %0d result transactions from %0d requests and noise runs.",
                 results_checked, req + 3);
        $display("Saw %0d credential, %0d favicon and %0d root events; %0d field bytes dropped.",
                 creds_seen, favicon_seen, root_seen, dropped_seen);
        if (fail_count == 0) begin
            $display("http_credential_query_parser regression: pass");
        end else begin
            $display("http_credential_query_parser regression: fail");
        end
        $finish;
    end

endmodule
